### sv/look_at_view_matrix_assert.svh
// Assertion macros shared by the look-at view matrix RTL.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LAVM_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LAVM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

### sv/lavm_pkg.sv
// Shared constants and types of the look-at view matrix pipeline.
`timescale 1ns / 1ps
package lavm_pkg;

  localparam int LAVM_FRAC_BITS = 16;
  localparam int EYE_W          = 32;
  localparam int SCALE_W        = 31;
  localparam int SUM_W          = 64;
  localparam int ROOT_W         = 32;
  localparam int ROOT_STEPS     = 32;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

### sv/look_at_view_matrix.sv
// Stages in order: depth normalizer, cross product, right normalizer, tail (Q15.16 by default).
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Most of the depth lies in the two normalizers, each with 32 square-root stages
// and FRAC_BITS+1 divider stages working on three lanes at once.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears flip_direction.
`timescale 1ns / 1ps
module look_at_view_matrix #(
  parameter int FRAC_BITS = lavm_pkg::LAVM_FRAC_BITS,
  localparam int OUT_W = ((3 * (3 * (FRAC_BITS + 2) + lavm_pkg::EYE_W) + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: bit 0 is flip_direction.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_data_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // From bit 0 up: eye_x, eye_y, eye_z, look_x, look_y, look_z, up_x, up_y, up_z.
  input  logic [287:0]       s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // From bit 0 up: right_x, right_y, right_z, right_shift, upward_x, upward_y,
  // upward_z, upward_shift, depth_x, depth_y, depth_z, depth_shift, zero fill.
  output logic [OUT_W-1:0]   m_axis_tdata_o
);
  import lavm_pkg::*;

  localparam int AXW   = FRAC_BITS + 2;
  localparam int ROW_W = 3 * AXW + EYE_W;
  localparam int DW    = EYE_W + 1;
  localparam int XW    = EYE_W + FRAC_BITS + 3;
  localparam int SW1   = 6 * EYE_W;
  localparam int SW2   = 3 * EYE_W + 3 * AXW;
  localparam logic [AXW-1:0] AX_ONE = AXW'(1) << FRAC_BITS;

  logic flip_q;
  logic en;

  pipe_ctl_t ctl_n1, ctl_cr, ctl_n2, ctl_tl;

  logic [2:0][EYE_W-1:0] eye_v, look_v, up_v;
  logic [2:0][DW-1:0]    dir;

  logic                  n1_vld, cr_vld, n2_vld, tl_vld;
  logic [2:0][AXW-1:0]   zx, zx2, xx;
  logic [SW1-1:0]        n1_side;
  logic [2:0][EYE_W-1:0] up1, eye1, eye2;
  logic [2:0][XW-1:0]    xr;
  logic [SW2-1:0]        cr_side, n2_side;

  logic [2:0][2:0][AXW-1:0]   ax;
  logic [2:0][EYE_W-1:0]      sh;

  // The direction flip is a plain register; the user must write it only while idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q <= 1'b0;
    end else if (cfg_valid_i) begin
      flip_q <= cfg_data_i[0];
    end
  end

  // One enable moves every stage at once. The last tail stage is the output
  // register, so the pipeline only holds when a finished result is not taken.
  assign en              = !tl_vld || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      eye_v[l]  = s_axis_tdata_i[EYE_W*l +: EYE_W];
      look_v[l] = s_axis_tdata_i[EYE_W*(3+l) +: EYE_W];
      up_v[l]   = s_axis_tdata_i[EYE_W*(6+l) +: EYE_W];
      // One extra bit so that negating the most negative value cannot wrap.
      dir[l] = flip_q ? -DW'($signed(look_v[l])) : DW'($signed(look_v[l]));
    end
  end

  assign ctl_n1 = '{en: en, vld: s_axis_tvalid_i};
  assign ctl_cr = '{en: en, vld: n1_vld};
  assign ctl_n2 = '{en: en, vld: cr_vld};
  assign ctl_tl = '{en: en, vld: n2_vld};

  // Depth axis: normalized viewing direction.
  lavm_norm #(
    .FRAC_BITS(FRAC_BITS),
    .VW       (DW),
    .SW       (SW1)
  ) u_norm_depth (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl_n1),
    .v_i   (dir),
    .side_i({up_v, eye_v}),
    .vld_o (n1_vld),
    .n_o   (zx),
    .side_o(n1_side)
  );

  assign up1  = n1_side[SW1-1 -: 3*EYE_W];
  assign eye1 = n1_side[3*EYE_W-1:0];

  // Unnormalized right axis, up cross depth, at double fraction precision.
  lavm_cross #(
    .FRAC_BITS(FRAC_BITS),
    .SW       (SW2)
  ) u_cross (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl_cr),
    .up_i  (up1),
    .z_i   (zx),
    .side_i({zx, eye1}),
    .vld_o (cr_vld),
    .xr_o  (xr),
    .side_o(cr_side)
  );

  // Right axis: normalized cross product; zero when up is parallel to depth.
  lavm_norm #(
    .FRAC_BITS(FRAC_BITS),
    .VW       (XW),
    .SW       (SW2)
  ) u_norm_right (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl_n2),
    .v_i   (xr),
    .side_i(cr_side),
    .vld_o (n2_vld),
    .n_o   (xx),
    .side_o(n2_side)
  );

  assign zx2  = n2_side[SW2-1 -: 3*AXW];
  assign eye2 = n2_side[3*EYE_W-1:0];

  // Upward axis and the three translations; its last stage feeds the port.
  lavm_tail #(
    .FRAC_BITS(FRAC_BITS)
  ) u_tail (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl_tl),
    .x_i   (xx),
    .z_i   (zx2),
    .eye_i (eye2),
    .vld_o (tl_vld),
    .ax_o  (ax),
    .sh_o  (sh)
  );

  assign m_axis_tvalid_o = tl_vld;

  always_comb begin
    m_axis_tdata_o = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_axis_tdata_o[ROW_W*r + AXW*c +: AXW] = ax[r][c];
      end
      m_axis_tdata_o[ROW_W*r + 3*AXW +: EYE_W] = sh[r];
    end
  end

  `include "look_at_view_matrix_assert.svh"

  // A waiting result must freeze the intake.
  `LAVM_ASSERT_IMPL(a_stall_blocks_intake, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o)
  // The direction mode changes only through a configuration write.
  `LAVM_ASSERT_NEXT(a_flip_only_on_write, !cfg_valid_i, $stable(flip_q))
  // The depth axis leaving the block stays within plus or minus one.
  `LAVM_ASSERT_IMPL(a_depth_in_range, m_axis_tvalid_o, ($signed(ax[2][0]) <= $signed(AX_ONE)) && ($signed(ax[2][0]) >= -$signed(AX_ONE)))

endmodule

### sv/lavm_norm.sv
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
`timescale 1ns / 1ps
module lavm_norm #(
  parameter int FRAC_BITS = lavm_pkg::LAVM_FRAC_BITS,
  parameter int VW        = 33,
  parameter int SW        = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lavm_pkg::pipe_ctl_t         ctl_i,
  input  logic [2:0][VW-1:0]          v_i,
  input  logic [SW-1:0]               side_i,
  output logic                        vld_o,
  output logic [2:0][FRAC_BITS+1:0]   n_o,
  output logic [SW-1:0]               side_o
);
  import lavm_pkg::*;

  localparam int QB  = FRAC_BITS + 1;
  localparam int AXW = FRAC_BITS + 2;
  localparam int PW  = $clog2(VW);
  localparam int NW  = SCALE_W + FRAC_BITS + 1;
  localparam int RS  = 6;
  localparam int DS  = RS + ROOT_STEPS;
  localparam int FS  = DS + QB;
  localparam int LAT = FS + 1;
  localparam int AW  = SW + 4;
  localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

  logic [LAT-1:0] vld_q;
  logic [AW-1:0]  aux_d;
  logic [AW-1:0]  aux_q [LAT];

  logic [2:0][VW-1:0]        mag0_d, mag0_q, mag1_q, mag2_q;
  logic [VW-1:0]             m1_d, m1_q;
  logic [PW-1:0]             pos2_d, pos2_q;
  logic [2:0][SCALE_W-1:0]   sc3_d, sc3_q, sc4_q, sc5_q;
  logic [2:0][2*SCALE_W-1:0] sq4_q;
  logic [SUM_W-1:0]          sum5_q;

  logic [SUM_W-1:0]        rs_s_in [ROOT_STEPS];
  logic [SUM_W-1:0]        rs_r_in [ROOT_STEPS];
  logic [2:0][SCALE_W-1:0] rs_m_in [ROOT_STEPS];
  logic [SUM_W-1:0]        rs_try  [ROOT_STEPS];
  logic [SUM_W-1:0]        rs_s_d  [ROOT_STEPS];
  logic [SUM_W-1:0]        rs_r_d  [ROOT_STEPS];
  logic [SUM_W-1:0]        rs_s_q  [ROOT_STEPS];
  logic [SUM_W-1:0]        rs_r_q  [ROOT_STEPS];
  logic [2:0][SCALE_W-1:0] rs_m_q  [ROOT_STEPS];

  logic [2:0][NW-1:0]      num;
  logic [ROOT_W-1:0]       dv_r_in   [QB];
  logic [2:0][ROOT_W-1:0]  dv_rem_in [QB];
  logic [2:0][QB-1:0]      dv_low_in [QB];
  logic [2:0][QB-1:0]      dv_quo_in [QB];
  logic [2:0][ROOT_W:0]    dv_try    [QB];
  logic [2:0][ROOT_W-1:0]  dv_rem_d  [QB];
  logic [2:0][QB-1:0]      dv_quo_d  [QB];
  logic [ROOT_W-1:0]       dv_r_q    [QB];
  logic [2:0][ROOT_W-1:0]  dv_rem_q  [QB];
  logic [2:0][QB-1:0]      dv_low_q  [QB];
  logic [2:0][QB-1:0]      dv_quo_q  [QB];

  logic [2:0][QB-1:0]  cap;
  logic [2:0][AXW-1:0] n_d, n_q;

  // Valid bits reset; the data beside them does not need to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[LAT-2:0], ctl_i.vld};
    end
  end

  // Sign bits and the zero flag ride along with the caller's side data.
  assign aux_d = {(v_i == '0), v_i[2][VW-1], v_i[1][VW-1], v_i[0][VW-1], side_i};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag0_d[l] = v_i[l][VW-1] ? (~v_i[l] + VW'(1)) : v_i[l];
    end
    m1_d = mag0_q[0];
    if (mag0_q[1] > m1_d) begin
      m1_d = mag0_q[1];
    end
    if (mag0_q[2] > m1_d) begin
      m1_d = mag0_q[2];
    end
    pos2_d = '0;
    for (int i = 0; i < VW; i++) begin
      if (m1_q[i]) begin
        pos2_d = PW'(i);
      end
    end
    // Scaling puts the leading one of the largest magnitude at bit 30.
    for (int l = 0; l < 3; l++) begin
      sc3_d[l] = SCALE_W'({mag2_q[l], {SCALE_W{1'b0}}} >> ((PW+1)'(pos2_q) + 1'b1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      aux_q[0] <= aux_d;
      for (int i = 1; i < LAT; i++) begin
        aux_q[i] <= aux_q[i-1];
      end
      mag0_q <= mag0_d;
      m1_q   <= m1_d;
      mag1_q <= mag0_q;
      pos2_q <= pos2_d;
      mag2_q <= mag1_q;
      sc3_q  <= sc3_d;
      for (int l = 0; l < 3; l++) begin
        sq4_q[l] <= sc3_q[l] * sc3_q[l];
      end
      sc4_q  <= sc3_q;
      sum5_q <= SUM_W'(sq4_q[0]) + SUM_W'(sq4_q[1]) + SUM_W'(sq4_q[2]);
      sc5_q  <= sc4_q;
    end
  end

  // Square root, one result bit per stage.
  always_comb begin
    rs_s_in[0] = sum5_q;
    rs_r_in[0] = '0;
    rs_m_in[0] = sc5_q;
    for (int k = 1; k < ROOT_STEPS; k++) begin
      rs_s_in[k] = rs_s_q[k-1];
      rs_r_in[k] = rs_r_q[k-1];
      rs_m_in[k] = rs_m_q[k-1];
    end
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rs_try[k] = rs_r_in[k] + (SUM_W'(1) << (2 * (ROOT_STEPS - 1 - k)));
      if (rs_s_in[k] >= rs_try[k]) begin
        rs_s_d[k] = rs_s_in[k] - rs_try[k];
        rs_r_d[k] = (rs_r_in[k] >> 1) + (SUM_W'(1) << (2 * (ROOT_STEPS - 1 - k)));
      end else begin
        rs_s_d[k] = rs_s_in[k];
        rs_r_d[k] = rs_r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
        rs_s_q[k] <= rs_s_d[k];
        rs_r_q[k] <= rs_r_d[k];
        rs_m_q[k] <= rs_m_in[k];
      end
    end
  end

  // Restoring division of the rounded numerator, one quotient bit per stage.
  always_comb begin
    dv_r_in[0] = rs_r_q[ROOT_STEPS-1][ROOT_W-1:0];
    for (int l = 0; l < 3; l++) begin
      num[l] = NW'({rs_m_q[ROOT_STEPS-1][l], {FRAC_BITS{1'b0}}}) + NW'(dv_r_in[0] >> 1);
      dv_rem_in[0][l] = ROOT_W'(num[l][NW-1:QB]);
      dv_low_in[0][l] = num[l][QB-1:0];
      dv_quo_in[0][l] = '0;
    end
    for (int j = 1; j < QB; j++) begin
      dv_r_in[j]   = dv_r_q[j-1];
      dv_rem_in[j] = dv_rem_q[j-1];
      dv_low_in[j] = dv_low_q[j-1];
      dv_quo_in[j] = dv_quo_q[j-1];
    end
    for (int j = 0; j < QB; j++) begin
      for (int l = 0; l < 3; l++) begin
        dv_try[j][l] = {dv_rem_in[j][l], dv_low_in[j][l][QB-1]};
        if (dv_try[j][l] >= {1'b0, dv_r_in[j]}) begin
          dv_rem_d[j][l] = ROOT_W'(dv_try[j][l] - {1'b0, dv_r_in[j]});
          dv_quo_d[j][l] = {dv_quo_in[j][l][QB-2:0], 1'b1};
        end else begin
          dv_rem_d[j][l] = dv_try[j][l][ROOT_W-1:0];
          dv_quo_d[j][l] = {dv_quo_in[j][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int j = 0; j < QB; j++) begin
        dv_r_q[j]   <= dv_r_in[j];
        dv_rem_q[j] <= dv_rem_d[j];
        dv_quo_q[j] <= dv_quo_d[j];
        for (int l = 0; l < 3; l++) begin
          dv_low_q[j][l] <= dv_low_in[j][l] << 1;
        end
      end
    end
  end

  // A zero vector has no root to divide by and normalizes to zero.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cap[l] = (dv_quo_q[QB-1][l] > ONE_Q) ? ONE_Q : dv_quo_q[QB-1][l];
      if (aux_q[FS-1][SW+3]) begin
        n_d[l] = '0;
      end else if (aux_q[FS-1][SW+l]) begin
        n_d[l] = -AXW'(cap[l]);
      end else begin
        n_d[l] = AXW'(cap[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      n_q <= n_d;
    end
  end

  assign vld_o  = vld_q[LAT-1];
  assign n_o    = n_q;
  assign side_o = aux_q[LAT-1][SW-1:0];

endmodule

### sv/lavm_cross.sv
// Exact cross product of the up vector with the depth axis, two stages.
`timescale 1ns / 1ps
module lavm_cross #(
  parameter int FRAC_BITS = lavm_pkg::LAVM_FRAC_BITS,
  parameter int SW        = 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lavm_pkg::pipe_ctl_t                    ctl_i,
  input  logic [2:0][lavm_pkg::EYE_W-1:0]        up_i,
  input  logic [2:0][FRAC_BITS+1:0]              z_i,
  input  logic [SW-1:0]                          side_i,
  output logic                                   vld_o,
  output logic [2:0][lavm_pkg::EYE_W+FRAC_BITS+2:0] xr_o,
  output logic [SW-1:0]                          side_o
);
  import lavm_pkg::*;

  localparam int PRW = EYE_W + FRAC_BITS + 2;
  localparam int XW  = PRW + 1;

  logic [1:0]           vld_q;
  logic [5:0][PRW-1:0]  p_d, p_q;
  logic [2:0][XW-1:0]   xr_d, xr_q;
  logic [SW-1:0]        side1_q, side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[0], ctl_i.vld};
    end
  end

  always_comb begin
    p_d[0] = $signed(up_i[1]) * $signed(z_i[2]);
    p_d[1] = $signed(up_i[2]) * $signed(z_i[1]);
    p_d[2] = $signed(up_i[2]) * $signed(z_i[0]);
    p_d[3] = $signed(up_i[0]) * $signed(z_i[2]);
    p_d[4] = $signed(up_i[0]) * $signed(z_i[1]);
    p_d[5] = $signed(up_i[1]) * $signed(z_i[0]);
    for (int l = 0; l < 3; l++) begin
      xr_d[l] = XW'($signed(p_q[2*l])) - XW'($signed(p_q[2*l+1]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      p_q     <= p_d;
      side1_q <= side_i;
      xr_q    <= xr_d;
      side2_q <= side1_q;
    end
  end

  assign vld_o  = vld_q[1];
  assign xr_o   = xr_q;
  assign side_o = side2_q;

endmodule

### sv/lavm_tail.sv
// Upward axis as depth cross right, then the three translations.
`timescale 1ns / 1ps
module lavm_tail #(
  parameter int FRAC_BITS = lavm_pkg::LAVM_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lavm_pkg::pipe_ctl_t               ctl_i,
  input  logic [2:0][FRAC_BITS+1:0]         x_i,
  input  logic [2:0][FRAC_BITS+1:0]         z_i,
  input  logic [2:0][lavm_pkg::EYE_W-1:0]   eye_i,
  output logic                              vld_o,
  output logic [2:0][2:0][FRAC_BITS+1:0]    ax_o,
  output logic [2:0][lavm_pkg::EYE_W-1:0]   sh_o
);
  import lavm_pkg::*;

  localparam int AXW = FRAC_BITS + 2;
  localparam int YPW = 2 * AXW;
  localparam int YDW = YPW + 1;
  localparam int DPW = AXW + EYE_W;
  localparam int DSW = DPW + 2;
  localparam logic [YDW-1:0] Y_HALF = YDW'(1) << (FRAC_BITS - 1);
  localparam logic [YDW-1:0] Y_ONE  = YDW'(1) << FRAC_BITS;
  localparam logic [DSW-1:0] D_HALF = DSW'(1) << (FRAC_BITS - 1);
  localparam logic [DSW-1:0] D_MAXP = DSW'(32'h7fff_ffff);
  localparam logic [DSW-1:0] D_MAXN = DSW'(33'h1_0000_0000) >> 1;

  logic [5:0] vld_q;

  logic [5:0][YPW-1:0]          yp_d, yp_q;
  logic [2:0][YDW-1:0]          yd_d, yd_q;
  logic [2:0][AXW-1:0]          y_d, y2_q;
  logic [2:0][AXW-1:0]          x0_q, x1_q, x2_q, z0_q, z1_q, z2_q;
  logic [2:0][EYE_W-1:0]        e0_q, e1_q, e2_q;
  logic [2:0][2:0][AXW-1:0]     ax2, ax3_q, ax4_q, ax5_q;
  logic [2:0][2:0][DPW-1:0]     dp_d, dp_q;
  logic [2:0][DSW-1:0]          ds_d, ds_q;
  logic [2:0][EYE_W-1:0]        sh_d, sh_q;
  logic [2:0]                   y_neg, d_neg;
  logic [2:0][YDW-1:0]          y_mag, y_rnd;
  logic [2:0][DSW-1:0]          d_mag, d_rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[4:0], ctl_i.vld};
    end
  end

  always_comb begin
    yp_d[0] = $signed(z_i[1]) * $signed(x_i[2]);
    yp_d[1] = $signed(z_i[2]) * $signed(x_i[1]);
    yp_d[2] = $signed(z_i[2]) * $signed(x_i[0]);
    yp_d[3] = $signed(z_i[0]) * $signed(x_i[2]);
    yp_d[4] = $signed(z_i[0]) * $signed(x_i[1]);
    yp_d[5] = $signed(z_i[1]) * $signed(x_i[0]);
    for (int l = 0; l < 3; l++) begin
      yd_d[l] = YDW'($signed(yp_q[2*l])) - YDW'($signed(yp_q[2*l+1]));
      // Round half away from zero, then clamp to plus or minus one.
      y_neg[l] = yd_q[l][YDW-1];
      y_mag[l] = y_neg[l] ? -yd_q[l] : yd_q[l];
      y_rnd[l] = (y_mag[l] + Y_HALF) >> FRAC_BITS;
      if (y_rnd[l] > Y_ONE) begin
        y_rnd[l] = Y_ONE;
      end
      y_d[l] = y_neg[l] ? -AXW'(y_rnd[l]) : AXW'(y_rnd[l]);
    end
    ax2[0] = x2_q;
    ax2[1] = y2_q;
    ax2[2] = z2_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        dp_d[r][c] = $signed(ax2[r][c]) * $signed(e2_q[c]);
      end
      ds_d[r] = DSW'($signed(dp_q[r][0])) + DSW'($signed(dp_q[r][1]))
              + DSW'($signed(dp_q[r][2]));
      // Negated, rounded dot product saturated to the 32-bit range.
      d_neg[r] = ds_q[r][DSW-1];
      d_mag[r] = d_neg[r] ? -ds_q[r] : ds_q[r];
      d_rnd[r] = (d_mag[r] + D_HALF) >> FRAC_BITS;
      if (d_neg[r]) begin
        sh_d[r] = (d_rnd[r] > D_MAXP) ? 32'h7fff_ffff : d_rnd[r][EYE_W-1:0];
      end else begin
        sh_d[r] = (d_rnd[r] > D_MAXN) ? 32'h8000_0000 : -d_rnd[r][EYE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      yp_q  <= yp_d;
      x0_q  <= x_i;
      z0_q  <= z_i;
      e0_q  <= eye_i;
      yd_q  <= yd_d;
      x1_q  <= x0_q;
      z1_q  <= z0_q;
      e1_q  <= e0_q;
      y2_q  <= y_d;
      x2_q  <= x1_q;
      z2_q  <= z1_q;
      e2_q  <= e1_q;
      ax3_q <= ax2;
      dp_q  <= dp_d;
      ax4_q <= ax3_q;
      ds_q  <= ds_d;
      ax5_q <= ax4_q;
      sh_q  <= sh_d;
    end
  end

  assign vld_o = vld_q[5];
  assign ax_o  = ax5_q;
  assign sh_o  = sh_q;

endmodule

### dv/look_at_view_matrix_test.sv
// Self-checking testbench for the look-at view matrix pipeline.
`timescale 1ns / 1ps
module look_at_view_matrix_test;
  import lavm_pkg::*;

  localparam int FB     = LAVM_FRAC_BITS;
  localparam int AXW    = FB + 2;
  localparam int OUT_W  = ((3 * (3 * AXW + EYE_W) + 7) / 8) * 8;
  localparam int PIPE_LAT = 2 * FB + 88;
  localparam longint ONE = longint'(1) << FB;

  // First field in the lowest bits, so it is declared last.
  typedef struct packed {
    logic signed [31:0] up_z, up_y, up_x;
    logic signed [31:0] look_z, look_y, look_x;
    logic signed [31:0] eye_z, eye_y, eye_x;
  } camera_t;

  typedef struct packed {
    logic [OUT_W-3*(3*AXW+32)-1:0] fill;
    logic signed [31:0]    depth_shift;
    logic signed [AXW-1:0] depth_z, depth_y, depth_x;
    logic signed [31:0]    upward_shift;
    logic signed [AXW-1:0] upward_z, upward_y, upward_x;
    logic signed [31:0]    right_shift;
    logic signed [AXW-1:0] right_z, right_y, right_x;
  } view_t;

  typedef struct {
    bit      flip;
    camera_t cam;
    bit      typed;
    view_t   view;
  } setup_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_data_i = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [287:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  always #4 clk_i = ~clk_i;

  look_at_view_matrix dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  bit     flip_mode;
  view_t  pending_views[$];
  int     error_count;
  int     hold_request;
  bit     sender_busy_burst;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // Floor square root, bit by bit.
  function automatic longint unsigned floor_sqrt(input longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Scale the magnitudes so the largest sits in [2^30, 2^31), then divide by the length.
  function automatic void unit_vector(input longint v[3], output longint n[3]);
    longint unsigned mag[3], top, total, root, q;
    top = 0;
    total = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) n[i] = 0;
      return;
    end
    while (top >= (longint'(1) << 31)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (top < (longint'(1) << 30)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) total += mag[i] * mag[i];
    root = floor_sqrt(total);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FB) + (root >> 1)) / root;
      if (q > ONE) q = ONE;
      n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // Round half away from zero to FB fraction bits.
  function automatic longint round_frac(input longint v);
    longint half;
    half = longint'(1) << (FB - 1);
    if (v >= 0) return (v + half) >>> FB;
    return -(((-v) + half) >>> FB);
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic logic [31:0] eye_offset(input longint a[3], input longint e[3]);
    longint t;
    t = -round_frac(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return 32'(t);
  endfunction

  function automatic view_t build_view(input camera_t c, input bit flip);
    longint eye[3], dir[3], up[3], zax[3], cr[3], xax[3], yax[3];
    view_t r;
    eye = '{longint'(c.eye_x), longint'(c.eye_y), longint'(c.eye_z)};
    dir = '{longint'(c.look_x), longint'(c.look_y), longint'(c.look_z)};
    up  = '{longint'(c.up_x), longint'(c.up_y), longint'(c.up_z)};
    if (flip) for (int i = 0; i < 3; i++) dir[i] = -dir[i];
    unit_vector(dir, zax);
    cr[0] = up[1] * zax[2] - up[2] * zax[1];
    cr[1] = up[2] * zax[0] - up[0] * zax[2];
    cr[2] = up[0] * zax[1] - up[1] * zax[0];
    unit_vector(cr, xax);
    yax[0] = clamp_unit(round_frac(zax[1] * xax[2] - zax[2] * xax[1]));
    yax[1] = clamp_unit(round_frac(zax[2] * xax[0] - zax[0] * xax[2]));
    yax[2] = clamp_unit(round_frac(zax[0] * xax[1] - zax[1] * xax[0]));
    r = '0;
    r.right_x = AXW'(xax[0]);  r.right_y = AXW'(xax[1]);  r.right_z = AXW'(xax[2]);
    r.upward_x = AXW'(yax[0]); r.upward_y = AXW'(yax[1]); r.upward_z = AXW'(yax[2]);
    r.depth_x = AXW'(zax[0]);  r.depth_y = AXW'(zax[1]);  r.depth_z = AXW'(zax[2]);
    r.right_shift  = eye_offset(xax, eye);
    r.upward_shift = eye_offset(yax, eye);
    r.depth_shift  = eye_offset(zax, eye);
    return r;
  endfunction

  function automatic logic [31:0] view_field(input view_t v, input int i);
    case (i)
      0: return 32'(v.right_x);   1: return 32'(v.right_y);
      2: return 32'(v.right_z);   3: return v.right_shift;
      4: return 32'(v.upward_x);  5: return 32'(v.upward_y);
      6: return 32'(v.upward_z);  7: return v.upward_shift;
      8: return 32'(v.depth_x);   9: return 32'(v.depth_y);
      10: return 32'(v.depth_z);  default: return v.depth_shift;
    endcase
  endfunction

  string field_names[12] = '{"right_x", "right_y", "right_z", "right_shift",
                             "upward_x", "upward_y", "upward_z", "upward_shift",
                             "depth_x", "depth_y", "depth_z", "depth_shift"};

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    view_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = view_t'(m_axis_tdata_o);
      if (pending_views.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_views.pop_front();
        for (int i = 0; i < 12; i++)
          if (view_field(got, i) !== view_field(want, i))
            report_mismatch($sformatf("%s got %h expected %h", field_names[i],
                                      view_field(got, i), view_field(want, i)));
        if (got.fill !== '0) report_mismatch("zero fill bits not zero");
      end
    end
  end

  // Receiver: random stall rate drawn periodically from four levels, plus a long hold on request.
  initial begin
    int stall_pct, tick;
    stall_pct = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      tick++;
      if (hold_request > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_request--;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic wait_drained();
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
  endtask

  task automatic write_flip(input bit value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    flip_mode = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  int burst_left;

  // Offer one camera request; valid stays high into the next request unless a gap follows.
  task automatic send_camera(input camera_t c, input bit typed, input view_t typed_view);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_views.push_back(typed ? typed_view : build_view(c, flip_mode));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'd0;
      4, 5: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic camera_t random_camera();
    camera_t c;
    c.eye_x = pick_word(); c.eye_y = pick_word(); c.eye_z = pick_word();
    c.look_x = pick_word(); c.look_y = pick_word(); c.look_z = pick_word();
    c.up_x = pick_word(); c.up_y = pick_word(); c.up_z = pick_word();
    case ($urandom_range(0, 19))
      0: begin
        // Up parallel to the direction: the side axis collapses to zero.
        c.up_x = c.look_x; c.up_y = c.look_y; c.up_z = c.look_z;
      end
      1: begin
        c.look_x = '0; c.look_y = '0; c.look_z = '0;
      end
      2: begin
        c.eye_x = $urandom; c.eye_y = $urandom; c.eye_z = $urandom;
        c.look_x = $urandom; c.look_y = $urandom; c.look_z = $urandom;
        c.up_x = $urandom; c.up_y = $urandom; c.up_z = $urandom;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic camera_t cam(input int ex, ey, ez, lx, ly, lz, ux, uy, uz);
    camera_t c;
    c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
    c.look_x = lx; c.look_y = ly; c.look_z = lz;
    c.up_x = ux; c.up_y = uy; c.up_z = uz;
    return c;
  endfunction

  setup_row_t directed[$];

  initial begin
    localparam int MAXI = 32'h7fff_ffff;
    localparam int MINI = 32'h8000_0000;
    localparam int U = 1 << FB;
    view_t zero_view, frame_view, parallel_view;
    bit configured;

    zero_view = '0;
    frame_view = '0;
    frame_view.right_x = AXW'(ONE);
    frame_view.upward_y = AXW'(ONE);
    frame_view.depth_z = AXW'(ONE);
    parallel_view = '0;
    parallel_view.depth_z = AXW'(ONE);

    // Typed-in rows: all zero, an axis-aligned frame, up along the direction, and a zero up vector.
    directed.push_back('{0, cam(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_view});
    directed.push_back('{0, cam(0, 0, 0, 0, 0, U, 0, U, 0), 1, frame_view});
    directed.push_back('{0, cam(0, 0, 0, 0, 0, U, 0, 0, 2 * U), 1, parallel_view});
    directed.push_back('{0, cam(0, 0, 0, 0, 0, U, 0, 0, 0), 1, parallel_view});
    directed.push_back('{0, cam(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MINI, MAXI),
                         0, zero_view});
    directed.push_back('{0, cam(MINI, MINI, MINI, MINI, MINI, MINI, MINI, MAXI, MINI),
                         0, zero_view});
    directed.push_back('{0, cam(MINI, MAXI, MINI, MINI, 0, 0, 0, U, 0), 0, zero_view});
    directed.push_back('{0, cam(-1, 1, -1, 1, 1, 1, -1, 1, 0), 0, zero_view});
    directed.push_back('{0, cam(MAXI, MINI, MAXI, 3, -5, 7, MAXI, MAXI, MINI), 0, zero_view});
    directed.push_back('{0, cam(12345, -6789, 101112, -U, 2 * U, -3 * U, U, U, U),
                         0, zero_view});
    directed.push_back('{1, cam(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_view});
    directed.push_back('{1, cam(MINI, 0, 0, MINI, 0, 0, 0, U, 0), 0, zero_view});
    directed.push_back('{1, cam(0, MAXI, 0, 0, MINI, 0, MINI, 0, 0), 0, zero_view});
    directed.push_back('{1, cam(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MINI, MAXI),
                         0, zero_view});
    directed.push_back('{1, cam(MINI, MINI, MINI, MINI, MINI, MINI, MINI, MAXI, MINI),
                         0, zero_view});
    directed.push_back('{1, cam(0, 0, 0, 0, 0, -U, 0, 0, U), 0, zero_view});
    directed.push_back('{1, cam(777, -888, 999, U, -U, U / 2, 0, U, 0), 0, zero_view});

    burst_left = 0;
    error_count = 0;
    hold_request = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    configured = 0;
    foreach (directed[i]) begin
      // Register writes only happen with the pipeline empty.
      if (!configured || directed[i].flip != flip_mode) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        wait_drained();
        write_flip(directed[i].flip);
        configured = 1;
      end
      send_camera(directed[i].cam, directed[i].typed, directed[i].view);
    end

    // Random phases, alternating the register; one phase holds the receiver off.
    for (int ph = 0; ph < 6; ph++) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      wait_drained();
      write_flip(ph % 2 == 0);
      if (ph == 2) hold_request = 3 * PIPE_LAT;
      for (int k = 0; k < 90; k++) send_camera(random_camera(), 0, zero_view);
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
